// ===== rtl/fplook_pkg.sv =====
`default_nettype none
package fplook_pkg;

   localparam int ANGLE_W   = 18;
   localparam int TRIG_W    = 16;
   localparam int POS_W     = 32;
   localparam int DELTA_W   = 16;
   localparam int SENS_W    = 16;
   localparam int FT_W      = 16;
   localparam int LIMIT_W   = 14;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;
   localparam int CORDIC_W  = 34;
   localparam int ATAN_W    = 28;

   localparam int TRIG_ITER_DEF = 16;
   localparam int TRIG_ITER_MAX = 24;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [TRIG_W-1:0]  trig_type;
   typedef logic signed [POS_W-1:0]   pos_type;

   localparam angle_type TWO_PI_Q13  = 18'sd51472;
   localparam angle_type PI_Q13      = 18'sd25736;
   localparam angle_type HALF_PI_Q13 = 18'sd12868;
   localparam angle_type ANGLE_MAX   = 18'sd131071;
   localparam angle_type ANGLE_MIN   = -18'sd131072;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   localparam logic [SENS_W-1:0]  SENS_RESET  = 16'd128;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd12725;

   localparam logic [CSR_IDX_W-1:0] CSR_SENSITIVITY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_LIMIT = 1'b1;

   localparam logic [ATAN_W-1:0] ATAN_Q28 [0:TRIG_ITER_MAX-1] = '{
      28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290, 28'd16755422,
      28'd8385879, 28'd4193963, 28'd2097109, 28'd1048571, 28'd524287,
      28'd262144, 28'd131072, 28'd65536, 28'd32768, 28'd16384, 28'd8192,
      28'd4096, 28'd2048, 28'd1024, 28'd512, 28'd256, 28'd128, 28'd64, 28'd32
   };

endpackage
`default_nettype wire

// ===== rtl/fplook_if.sv =====
`default_nettype none
interface fplook_req_if import fplook_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [DELTA_W-1:0] mouse_dx;
   logic signed [DELTA_W-1:0] mouse_dy;
   logic [FT_W-1:0]           frame_time;
   pos_type                   pos_x;
   pos_type                   pos_y;
   pos_type                   pos_z;

   modport source (output valid, mouse_dx, mouse_dy, frame_time, pos_x, pos_y, pos_z,
                   input ready);
   modport sink (input valid, mouse_dx, mouse_dy, frame_time, pos_x, pos_y, pos_z,
                 output ready);
endinterface

interface fplook_rsp_if import fplook_pkg::*; ();
   logic      valid;
   logic      ready;
   pos_type   target_x;
   pos_type   target_y;
   pos_type   target_z;
   angle_type yaw_out;
   angle_type pitch_out;

   modport source (output valid, target_x, target_y, target_z, yaw_out, pitch_out,
                   input ready);
   modport sink (input valid, target_x, target_y, target_z, yaw_out, pitch_out,
                 output ready);
endinterface

interface fplook_csr_if import fplook_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/fplook_mul.sv =====
`default_nettype none
module fplook_mul import fplook_pkg::*; #(
   parameter int A_W = 32,
   parameter int B_W = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [A_W-1:0]     a,
   input  wire logic [B_W-1:0]     b,
   output logic                    done,
   output logic [A_W+B_W-1:0]      prod
);
   localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(B_W - 1);

   logic [A_W-1:0]     a_ff;
   logic [A_W+B_W-1:0] p_ff, p_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [A_W:0]       sum;

   // one multiplier bit per cycle, lsb first
   always_comb begin
      sum  = {1'b0, p_ff[A_W+B_W-1:B_W]} + (p_ff[0] ? {1'b0, a_ff} : '0);
      p_in = {sum, p_ff[B_W-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            a_ff    <= a;
            p_ff    <= {{A_W{1'b0}}, b};
         end else if (busy_ff) begin
            p_ff   <= p_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign prod = p_ff;

   ap_mul_starts: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && cnt_ff == '0)
      else $error("multiplier did not begin on start");
   ap_mul_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("multiplier done while still busy");
endmodule
`default_nettype wire

// ===== rtl/fplook_cordic.sv =====
`default_nettype none
module fplook_cordic import fplook_pkg::*; #(
   parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   input  wire angle_type angle,
   output logic           done,
   output trig_type       sin_val,
   output trig_type       cos_val
);
   localparam int N = (TRIG_ITERATIONS > TRIG_ITER_MAX) ? TRIG_ITER_MAX : TRIG_ITERATIONS;
   localparam int CNT_W = $clog2(TRIG_ITER_MAX);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(N - 1);
   localparam logic signed [CORDIC_W-1:0] RND = 34'sd32768;
   localparam logic signed [CORDIC_W-1:0] T_MAX = 34'sd16384;

   typedef logic signed [CORDIC_W-1:0] word_type;

   word_type         x_ff, y_ff, z_ff;
   logic             neg_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;

   angle_type a1, a2;
   logic      neg0;
   word_type  z0, xs, ys, at, xr, yr;
   trig_type  xq, yq;

   // range reduction into [-pi/2, pi/2]
   always_comb begin
      if (angle > PI_Q13)       a1 = angle - TWO_PI_Q13;
      else if (angle < -PI_Q13) a1 = angle + TWO_PI_Q13;
      else                      a1 = angle;
      neg0 = 1'b1;
      if (a1 > HALF_PI_Q13)       a2 = a1 - PI_Q13;
      else if (a1 < -HALF_PI_Q13) a2 = a1 + PI_Q13;
      else begin
         a2   = a1;
         neg0 = 1'b0;
      end
      z0 = word_type'(a2) <<< 15;
   end

   always_comb begin
      xs = x_ff >>> cnt_ff;
      ys = y_ff >>> cnt_ff;
      at = word_type'({1'b0, ATAN_Q28[cnt_ff]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            x_ff    <= CORDIC_GAIN_Q30;
            y_ff    <= '0;
            z_ff    <= z0;
            neg_ff  <= neg0;
         end else if (busy_ff) begin
            if (!z_ff[CORDIC_W-1]) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + at;
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // round to q1.14 and saturate
   always_comb begin
      xr = (x_ff + RND) >>> 16;
      yr = (y_ff + RND) >>> 16;
      if (xr > T_MAX)       xq = trig_type'(T_MAX);
      else if (xr < -T_MAX) xq = trig_type'(-T_MAX);
      else                  xq = xr[TRIG_W-1:0];
      if (yr > T_MAX)       yq = trig_type'(T_MAX);
      else if (yr < -T_MAX) yq = trig_type'(-T_MAX);
      else                  yq = yr[TRIG_W-1:0];
      sin_val = neg_ff ? -yq : yq;
      cos_val = neg_ff ? -xq : xq;
   end

   assign done = done_ff;
endmodule
`default_nettype wire

// ===== rtl/first_person_look_direction.sv =====
`default_nettype none
// requests: a new request is taken only once the previous result is in the output register;
// the bit-serial angle multiplier runs four times and the shared cordic unit twice per request
// a finished result waits in the output register while the next request is taken
// reset: synchronous, active high; yaw and pitch clear to zero, sensitivity to 0.5,
// pitch limit to 89 degrees
module first_person_look_direction import fplook_pkg::*; #(
   parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   fplook_req_if.sink  req_ch,
   fplook_rsp_if.source rsp_ch,
   fplook_csr_if.sink  csr_ch
);
   localparam int MA_W = 2 * SENS_W;
   localparam int MP_W = MA_W + FT_W;
   localparam int STEP_W = MP_W - 11;
   localparam int WIDE_W = STEP_W + 3;
   localparam int DIR_W = 2 * TRIG_W - 12;
   localparam int SUM_W = POS_W + 2;

   typedef enum logic [3:0] {
      S_IDLE, S_MA_GO, S_MA_WAIT, S_MB_GO, S_MB_WAIT,
      S_TRIG_GO, S_TRIG_WAIT, S_PROD_X, S_PROD_Z, S_OUT
   } state_type;

   state_type state_ff;
   logic      sel_ff;

   logic signed [DELTA_W-1:0] dx_ff, dy_ff;
   logic [FT_W-1:0]           ft_ff;
   pos_type                   px_ff, py_ff, pz_ff;
   logic [SENS_W-1:0]         sens_ff;
   logic [LIMIT_W-1:0]        lim_ff;
   angle_type                 yaw_ff, pitch_ff;
   logic [MA_W-1:0]           prod1_ff;
   trig_type                  sy_ff, cy_ff, sp_ff, cp_ff;
   logic signed [DIR_W-1:0]   dxo_ff, dzo_ff;

   logic      rsp_valid_ff;
   pos_type   tx_ff, ty_ff, tz_ff;
   angle_type yaw_out_ff, pitch_out_ff;

   // multiplier hookup
   logic                mul_start, mul_done;
   logic [MA_W-1:0]     mul_a;
   logic [FT_W-1:0]     mul_b;
   logic [MP_W-1:0]     mul_prod;
   logic                d_neg;
   logic [DELTA_W-1:0]  d_mag;

   always_comb begin
      d_neg     = sel_ff ? dy_ff[DELTA_W-1] : dx_ff[DELTA_W-1];
      d_mag     = sel_ff ? (d_neg ? -dy_ff : dy_ff) : (d_neg ? -dx_ff : dx_ff);
      mul_start = (state_ff == S_MA_GO) || (state_ff == S_MB_GO);
      mul_a     = (state_ff == S_MB_GO) ? prod1_ff : {{(MA_W-SENS_W){1'b0}}, sens_ff};
      mul_b     = (state_ff == S_MB_GO) ? ft_ff : d_mag;
   end

   fplook_mul #(.A_W(MA_W), .B_W(FT_W)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   // angle update: round, subtract, saturate, then clamp or wrap
   logic [MP_W-1:0]           rnd;
   logic signed [WIDE_W-1:0]  old_w, step_w, new_w;
   angle_type                 sat_a, lim_a, clamp_a, wrap1, wrap2;

   always_comb begin
      rnd    = mul_prod + MP_W'(1024);
      step_w = WIDE_W'({3'b0, rnd[MP_W-1:11]});
      old_w  = WIDE_W'(sel_ff ? pitch_ff : yaw_ff);
      new_w  = d_neg ? old_w + step_w : old_w - step_w;
      if (new_w > WIDE_W'(ANGLE_MAX))      sat_a = ANGLE_MAX;
      else if (new_w < WIDE_W'(ANGLE_MIN)) sat_a = ANGLE_MIN;
      else                                 sat_a = new_w[ANGLE_W-1:0];
      lim_a = angle_type'({1'b0, lim_ff});
      if (sat_a > lim_a)       clamp_a = lim_a;
      else if (sat_a < -lim_a) clamp_a = -lim_a;
      else                     clamp_a = sat_a;
      // remainder toward zero, at most two steps of two pi
      if (sat_a >= TWO_PI_Q13)       wrap1 = sat_a - TWO_PI_Q13;
      else if (sat_a <= -TWO_PI_Q13) wrap1 = sat_a + TWO_PI_Q13;
      else                           wrap1 = sat_a;
      if (wrap1 >= TWO_PI_Q13)       wrap2 = wrap1 - TWO_PI_Q13;
      else if (wrap1 <= -TWO_PI_Q13) wrap2 = wrap1 + TWO_PI_Q13;
      else                           wrap2 = wrap1;
   end

   // trig unit
   logic     trig_start, trig_done;
   trig_type trig_sin, trig_cos;

   assign trig_start = (state_ff == S_TRIG_GO);

   fplook_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (trig_start),
      .angle   (sel_ff ? pitch_ff : yaw_ff),
      .done    (trig_done),
      .sin_val (trig_sin),
      .cos_val (trig_cos)
   );

   // direction products and targets
   logic signed [2*TRIG_W-1:0] dprod;
   logic signed [SUM_W-1:0]    sx, sy_sum, sz, dyo;
   pos_type                    tx, ty, tz;

   function automatic pos_type sat_pos(input logic signed [SUM_W-1:0] v);
      pos_type r;
      if (v > SUM_W'(32'sh7fffffff))       r = 32'sh7fffffff;
      else if (v < -SUM_W'(33'sh80000000)) r = 32'sh80000000;
      else                                 r = v[POS_W-1:0];
      return r;
   endfunction

   always_comb begin
      dprod  = (state_ff == S_PROD_X ? sy_ff : cy_ff) * cp_ff;
      dprod  = dprod + 32'sd2048;
      dyo    = -(SUM_W'(sp_ff) <<< 2);
      sx     = SUM_W'(px_ff) - SUM_W'(dxo_ff);
      sy_sum = SUM_W'(py_ff) - dyo;
      sz     = SUM_W'(pz_ff) - SUM_W'(dzo_ff);
      tx     = sat_pos(sx);
      ty     = sat_pos(sy_sum);
      tz     = sat_pos(sz);
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= 1'b0;
         yaw_ff       <= '0;
         pitch_ff     <= '0;
         sens_ff      <= SENS_RESET;
         lim_ff       <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               CSR_SENSITIVITY: sens_ff <= csr_ch.data;
               CSR_PITCH_LIMIT: lim_ff  <= csr_ch.data[LIMIT_W-1:0];
               default: ;
            endcase
         end
         // in S_OUT the reload below owns the valid flag
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  dx_ff    <= req_ch.mouse_dx;
                  dy_ff    <= req_ch.mouse_dy;
                  ft_ff    <= req_ch.frame_time;
                  px_ff    <= req_ch.pos_x;
                  py_ff    <= req_ch.pos_y;
                  pz_ff    <= req_ch.pos_z;
                  sel_ff   <= 1'b0;
                  state_ff <= S_MA_GO;
               end
            end
            S_MA_GO: state_ff <= S_MA_WAIT;
            S_MA_WAIT: begin
               if (mul_done) begin
                  prod1_ff <= mul_prod[MA_W-1:0];
                  state_ff <= S_MB_GO;
               end
            end
            S_MB_GO: state_ff <= S_MB_WAIT;
            S_MB_WAIT: begin
               if (mul_done) begin
                  if (!sel_ff) begin
                     yaw_ff   <= wrap2;
                     sel_ff   <= 1'b1;
                     state_ff <= S_MA_GO;
                  end else begin
                     pitch_ff <= clamp_a;
                     sel_ff   <= 1'b0;
                     state_ff <= S_TRIG_GO;
                  end
               end
            end
            S_TRIG_GO: state_ff <= S_TRIG_WAIT;
            S_TRIG_WAIT: begin
               if (trig_done) begin
                  if (!sel_ff) begin
                     sy_ff    <= trig_sin;
                     cy_ff    <= trig_cos;
                     sel_ff   <= 1'b1;
                     state_ff <= S_TRIG_GO;
                  end else begin
                     sp_ff    <= trig_sin;
                     cp_ff    <= trig_cos;
                     state_ff <= S_PROD_X;
                  end
               end
            end
            S_PROD_X: begin
               dxo_ff   <= dprod[2*TRIG_W-1:12];
               state_ff <= S_PROD_Z;
            end
            S_PROD_Z: begin
               dzo_ff   <= dprod[2*TRIG_W-1:12];
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  tx_ff        <= tx;
                  ty_ff        <= ty;
                  tz_ff        <= tz;
                  yaw_out_ff   <= yaw_ff;
                  pitch_out_ff <= pitch_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.target_x  = tx_ff;
   assign rsp_ch.target_y  = ty_ff;
   assign rsp_ch.target_z  = tz_ff;
   assign rsp_ch.yaw_out   = yaw_out_ff;
   assign rsp_ch.pitch_out = pitch_out_ff;

   ap_yaw_wrapped: assert property (@(posedge clock) disable iff (reset)
      yaw_ff > -TWO_PI_Q13 && yaw_ff < TWO_PI_Q13)
      else $error("yaw outside one turn");
   ap_pitch_bounded: assert property (@(posedge clock) disable iff (reset)
      pitch_ff <= 18'sd16383 && pitch_ff >= -18'sd16383)
      else $error("pitch beyond any clamp");
   ap_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff == S_MA_GO)
      else $error("request accepted but work not started");
   ap_out_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && (!rsp_valid_ff || rsp_ch.ready) |=> rsp_valid_ff)
      else $error("result not presented");
endmodule
`default_nettype wire

// ===== dv/first_person_look_direction_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module first_person_look_direction_test;
   import fplook_pkg::*;

   localparam int ITER = 16;
   localparam int PERIOD_HALF = 6;

   typedef struct packed {
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic [FT_W-1:0]           ft;
      pos_type                   px;
      pos_type                   py;
      pos_type                   pz;
   } frame_type;

   typedef struct packed {
      pos_type   tx;
      pos_type   ty;
      pos_type   tz;
      angle_type yaw;
      angle_type pitch;
   } target_type;

   typedef struct packed {
      logic                 is_csr;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DAT_W-1:0] dat;
      frame_type            frame;
   } op_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fplook_req_if req_ch ();
   fplook_rsp_if rsp_ch ();
   fplook_csr_if csr_ch ();

   first_person_look_direction #(.TRIG_ITERATIONS(ITER)) u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source),
      .csr_ch(csr_ch.sink)
   );

   always begin
      #PERIOD_HALF clock = 1'b1;
      #PERIOD_HALF clock = 1'b0;
   end

   // predictor state
   longint cam_sens, cam_limit, cam_yaw, cam_pitch;
   target_type expected_targets[$];
   op_type     pending_ops[$];
   int      errors = 0;
   bit      stim_done = 1'b0;
   int      hold_cycles = 0;
   int      in_flight = 0;

   function automatic longint fl_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint turn_step(longint d, longint ft);
      longint p, m, r;
      p = d * cam_sens * ft;
      m = p < 0 ? -p : p;
      r = (m + 1024) >>> 11;
      return p < 0 ? -r : r;
   endfunction

   task automatic sin_cos(input longint a_in, output longint s, output longint c);
      longint a, x, y, z, xs, ys;
      bit neg;
      a = a_in;
      neg = 1'b0;
      x = CORDIC_GAIN_Q30;
      y = 0;
      while (a > PI_Q13) a -= TWO_PI_Q13;
      while (a < -PI_Q13) a += TWO_PI_Q13;
      if (a > HALF_PI_Q13) begin
         a -= PI_Q13;
         neg = 1'b1;
      end else if (a < -HALF_PI_Q13) begin
         a += PI_Q13;
         neg = 1'b1;
      end
      z = a * 32768;
      for (int i = 0; i < ITER && i < TRIG_ITER_MAX; i++) begin
         xs = fl_shift(x, i);
         ys = fl_shift(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(ATAN_Q28[i]);
         end else begin
            x += ys; y -= xs; z += longint'(ATAN_Q28[i]);
         end
      end
      x = clip(fl_shift(x + 32768, 16), -16384, 16384);
      y = clip(fl_shift(y + 32768, 16), -16384, 16384);
      s = neg ? -y : y;
      c = neg ? -x : x;
   endtask

   task automatic predict_target(input frame_type f);
      longint sy, cy, sp, cp, dxo, dyo, dzo;
      target_type t;
      cam_yaw = clip(cam_yaw - turn_step(f.dx, f.ft), -131072, 131071);
      cam_pitch = clip(cam_pitch - turn_step(f.dy, f.ft), -131072, 131071);
      cam_pitch = clip(cam_pitch, -cam_limit, cam_limit);
      cam_yaw = cam_yaw % 51472;
      sin_cos(cam_yaw, sy, cy);
      sin_cos(cam_pitch, sp, cp);
      dxo = fl_shift(sy * cp + 2048, 12);
      dyo = -sp * 4;
      dzo = fl_shift(cy * cp + 2048, 12);
      t.tx = 32'(clip(longint'(f.px) - dxo, -64'sd2147483648, 64'sd2147483647));
      t.ty = 32'(clip(longint'(f.py) - dyo, -64'sd2147483648, 64'sd2147483647));
      t.tz = 32'(clip(longint'(f.pz) - dzo, -64'sd2147483648, 64'sd2147483647));
      t.yaw = ANGLE_W'(cam_yaw);
      t.pitch = ANGLE_W'(cam_pitch);
      expected_targets.push_back(t);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic frame_type rand_frame();
      frame_type f;
      int k;
      f.dx = 16'($urandom);
      f.dy = 16'($urandom);
      f.ft = 16'($urandom);
      f.px = $urandom;
      f.py = $urandom;
      f.pz = $urandom;
      k = $urandom_range(0, 9);
      // mostly modest deltas and frame times so the angles move through all quadrants
      if (k < 6) begin
         f.dx = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
         f.dy = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
         f.ft = 16'($urandom_range(0, 2000));
      end else if (k < 7) begin
         f.ft = '0;
      end
      return f;
   endfunction

   function automatic op_type frame_op(frame_type f);
      op_type o;
      o = '0;
      o.frame = f;
      return o;
   endfunction

   function automatic op_type csr_op(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] dat);
      op_type o;
      o = '0;
      o.is_csr = 1'b1;
      o.idx = idx;
      o.dat = dat;
      return o;
   endfunction

   // driver
   int  req_gap = 0;
   bit  drain_wait = 1'b0;
   int  settle = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         csr_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) in_flight = in_flight + 1;
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == CSR_SENSITIVITY) cam_sens = csr_ch.data;
            else cam_limit = csr_ch.data;
         end
         if ((req_ch.valid && !req_ch.ready) || (csr_ch.valid && !csr_ch.ready)) begin
            // hold the current request
         end else if (req_gap > 0) begin
            req_ch.valid <= 1'b0;
            csr_ch.valid <= 1'b0;
            req_gap--;
         end else if (pending_ops.size() == 0) begin
            req_ch.valid <= 1'b0;
            csr_ch.valid <= 1'b0;
         end else if (pending_ops[0].is_csr) begin
            req_ch.valid <= 1'b0;
            // register writes only once the block has drained
            if (expected_targets.size() != 0 || (req_ch.valid && req_ch.ready)) begin
               csr_ch.valid <= 1'b0;
               settle = 0;
            end else if (settle < 150) begin
               csr_ch.valid <= 1'b0;
               settle++;
            end else begin
               settle = 0;
               csr_ch.valid <= 1'b1;
               csr_ch.index <= pending_ops[0].idx;
               csr_ch.data  <= pending_ops[0].dat;
               void'(pending_ops.pop_front());
               req_gap = pick_gap();
            end
         end else begin
            csr_ch.valid <= 1'b0;
            req_ch.valid      <= 1'b1;
            req_ch.mouse_dx   <= pending_ops[0].frame.dx;
            req_ch.mouse_dy   <= pending_ops[0].frame.dy;
            req_ch.frame_time <= pending_ops[0].frame.ft;
            req_ch.pos_x      <= pending_ops[0].frame.px;
            req_ch.pos_y      <= pending_ops[0].frame.py;
            req_ch.pos_z      <= pending_ops[0].frame.pz;
            predict_target(pending_ops[0].frame);
            void'(pending_ops.pop_front());
            req_gap = pick_gap();
         end
         if (pending_ops.size() == 0 && !req_ch.valid && !csr_ch.valid) stim_done = 1'b1;
      end
   end

   // monitor
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_targets.size() == 0) begin
               $display("%0t: unexpected target x=%h", $time, rsp_ch.target_x);
               errors++;
            end else begin
               target_type e;
               e = expected_targets.pop_front();
               if (rsp_ch.target_x !== e.tx) begin
                  $display("%0t: target_x exp %h got %h", $time, e.tx, rsp_ch.target_x);
                  errors++;
               end
               if (rsp_ch.target_y !== e.ty) begin
                  $display("%0t: target_y exp %h got %h", $time, e.ty, rsp_ch.target_y);
                  errors++;
               end
               if (rsp_ch.target_z !== e.tz) begin
                  $display("%0t: target_z exp %h got %h", $time, e.tz, rsp_ch.target_z);
                  errors++;
               end
               if (rsp_ch.yaw_out !== e.yaw) begin
                  $display("%0t: yaw exp %h got %h", $time, e.yaw, rsp_ch.yaw_out);
                  errors++;
               end
               if (rsp_ch.pitch_out !== e.pitch) begin
                  $display("%0t: pitch exp %h got %h", $time, e.pitch, rsp_ch.pitch_out);
                  errors++;
               end
            end
         end
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles--;
         end else if (rsp_gap > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (rsp_ch.valid && rsp_ch.ready) rsp_gap = pick_gap();
         end
      end
   end

   initial begin
      frame_type f;
      req_ch.valid = 1'b0;
      req_ch.mouse_dx = '0;
      req_ch.mouse_dy = '0;
      req_ch.frame_time = '0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.pos_z = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
      cam_sens = SENS_RESET;
      cam_limit = LIMIT_RESET;
      cam_yaw = 0;
      cam_pitch = 0;

      // directed: field extremes at reset settings
      f = '{16'sd0, 16'sd0, 16'd0, 32'sd0, 32'sd0, 32'sd0};
      pending_ops.push_back(frame_op(f));
      f = '{16'sd32767, 16'sd32767, 16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
      pending_ops.push_back(frame_op(f));
      f = '{16'sh8000, 16'sh8000, 16'hFFFF, 32'h80000000, 32'h80000000, 32'h80000000};
      pending_ops.push_back(frame_op(f));
      f = '{16'sd300, -16'sd300, 16'd4000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000};
      pending_ops.push_back(frame_op(f));
      // large sensitivity drives the angle into saturation
      pending_ops.push_back(csr_op(CSR_SENSITIVITY, 16'hFFFF));
      pending_ops.push_back(csr_op(CSR_PITCH_LIMIT, 16'h3FFF));
      f = '{16'sh8000, 16'sd32767, 16'hFFFF, 32'sd0, 32'sd0, 32'sd0};
      pending_ops.push_back(frame_op(f));
      f = '{16'sd32767, 16'sh8000, 16'hFFFF, 32'sd1, -32'sd1, 32'sd65536};
      pending_ops.push_back(frame_op(f));
      f = '{16'sd100, 16'sd100, 16'd50, 32'sd0, 32'sd0, 32'sd0};
      pending_ops.push_back(frame_op(f));
      // zero sensitivity, zero pitch limit
      pending_ops.push_back(csr_op(CSR_SENSITIVITY, 16'h0000));
      pending_ops.push_back(csr_op(CSR_PITCH_LIMIT, 16'h0000));
      f = '{16'sd32767, 16'sd32767, 16'hFFFF, 32'sd5, 32'sd6, 32'sd7};
      pending_ops.push_back(frame_op(f));
      pending_ops.push_back(csr_op(CSR_SENSITIVITY, 16'd256));
      f = '{16'sd1000, 16'sd1000, 16'd3000, 32'sd0, 32'sd0, 32'sd0};
      pending_ops.push_back(frame_op(f));

      // random phases with varied settings
      for (int ph = 0; ph < 6; ph++) begin
         pending_ops.push_back(csr_op(CSR_SENSITIVITY,
            ph == 0 ? SENS_RESET : 16'($urandom)));
         pending_ops.push_back(csr_op(CSR_PITCH_LIMIT,
            ph == 0 ? 16'(LIMIT_RESET) : 16'($urandom_range(0, 16383))));
         for (int n = 0; n < 150; n++) pending_ops.push_back(frame_op(rand_frame()));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // long receiver stall while requests keep coming
      repeat (300) @(posedge clock);
      hold_cycles = 2000;
      wait (stim_done && expected_targets.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0 && expected_targets.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
